// ----- design/bfdd_pkg.sv -----
// Shared types and constants for the byte frame digit decoder.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package bfdd_pkg;

   // Field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned DIGIT_W  = 4;
   localparam int unsigned NUMBER_W = 15;
   localparam int unsigned CSR_IDX_W = 1;

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [DIGIT_W-1:0]  digit_type;
   typedef logic [NUMBER_W-1:0] number_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   // Update kinds reported with each decoded frame
   localparam kind_type KIND_TARGET = 2'd0;
   localparam kind_type KIND_NUMBER = 2'd1;
   localparam kind_type KIND_NONE   = 2'd2;

   // Configuration register indexes
   localparam csr_index_type REG_HEADER = 1'd0;
   localparam csr_index_type REG_TAIL   = 1'd1;

   // Reset values of the frame delimiters
   localparam byte_type HEADER_RESET = 8'h55;
   localparam byte_type TAIL_RESET   = 8'h6B;

   // Largest number a four-digit frame can produce (all digits fifteen)
   localparam number_type NUMBER_MAX = 15'd16665;

endpackage

// ----- design/bfdd_chan_if.sv -----
// Valid/ready channel interfaces for request bytes and decoded results.
// Depends on bfdd_pkg.
`timescale 1ns / 1ps

interface bfdd_req_if;
   logic              valid;
   logic              ready;
   bfdd_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bfdd_rsp_if;
   logic                valid;
   logic                ready;
   bfdd_pkg::kind_type   update_kind;
   bfdd_pkg::digit_type  target_value;
   bfdd_pkg::number_type number_value;

   modport source (output valid, output update_kind, output target_value,
                   output number_value, input ready);
   modport sink   (input valid, input update_kind, input target_value,
                   input number_value, output ready);
endinterface

// ----- design/byte_frame_digit_decoder.sv -----
// A tail byte passes through the input register and then the result register.
// Throughput: one request byte per cycle; the input register and the result
// register each advance whenever the result register is empty or taken.
// Reset: synchronous, active high; clears the frame position, the stored
// target and number, the valid flags, and restores header 0x55, tail 0x6B.
// Depends on bfdd_pkg and bfdd_chan_if.
`timescale 1ns / 1ps

module byte_frame_digit_decoder (
   input  logic                    clock,
   input  logic                    reset,
   bfdd_req_if.sink                req_if,
   bfdd_rsp_if.source              rsp_if,
   input  logic                    csr_wr_en,
   input  bfdd_pkg::csr_index_type csr_index,
   input  bfdd_pkg::byte_type      csr_wdata
);

   // Frame position codes
   localparam logic [1:0] POS_HEADER = 2'd0;
   localparam logic [1:0] POS_FIRST  = 2'd1;
   localparam logic [1:0] POS_SECOND = 2'd2;
   localparam logic [1:0] POS_TAIL   = 2'd3;

   bfdd_pkg::byte_type   header_ff, tail_ff;
   logic                 in_valid_ff;
   bfdd_pkg::byte_type   in_byte_ff;
   logic [1:0]           pos_ff, pos_in;
   bfdd_pkg::byte_type   pay_first_ff, pay_second_ff;
   bfdd_pkg::digit_type  target_ff, target_in;
   bfdd_pkg::number_type number_ff, number_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bfdd_pkg::kind_type   rsp_kind_ff, kind_in;

   logic                 advance;
   logic                 consume;
   logic                 frame_done;
   bfdd_pkg::digit_type  d1, d2, d3, d4;
   bfdd_pkg::number_type w1, w2, w3, w4;

   // Handshake: the result register empties or is taken this cycle
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign consume      = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= bfdd_pkg::HEADER_RESET;
         tail_ff   <= bfdd_pkg::TAIL_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == bfdd_pkg::REG_HEADER) begin
            header_ff <= csr_wdata;
         end else begin
            tail_ff <= csr_wdata;
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_byte_ff <= req_if.rx_byte;
      end
   end

   // Digit split and widening to the number width
   assign d1 = pay_first_ff[7:4];
   assign d2 = pay_first_ff[3:0];
   assign d3 = pay_second_ff[7:4];
   assign d4 = pay_second_ff[3:0];
   assign w1 = bfdd_pkg::number_type'(d1);
   assign w2 = bfdd_pkg::number_type'(d2);
   assign w3 = bfdd_pkg::number_type'(d3);
   assign w4 = bfdd_pkg::number_type'(d4);

   // Frame tracking and decode
   always_comb begin
      pos_in       = pos_ff;
      target_in    = target_ff;
      number_in    = number_ff;
      kind_in      = bfdd_pkg::KIND_NONE;
      frame_done   = 1'b0;
      unique case (pos_ff)
         POS_HEADER: begin
            if (in_byte_ff == header_ff) pos_in = POS_FIRST;
         end
         POS_FIRST:  pos_in = POS_SECOND;
         POS_SECOND: pos_in = POS_TAIL;
         POS_TAIL: begin
            pos_in = POS_HEADER;
            if (in_byte_ff == tail_ff) begin
               frame_done = 1'b1;
               if (d1 == '0) begin
                  kind_in = bfdd_pkg::KIND_NONE;
               end else if (d2 == '0 && d3 == '0 && d4 == '0) begin
                  kind_in   = bfdd_pkg::KIND_TARGET;
                  target_in = d1;
               end else if (d2 != '0 && d3 == '0 && d4 == '0) begin
                  kind_in   = bfdd_pkg::KIND_NUMBER;
                  number_in = w1 * 15'd10 + w2;
               end else if (d2 != '0 && d3 != '0 && d4 == '0) begin
                  kind_in   = bfdd_pkg::KIND_NUMBER;
                  number_in = w1 * 15'd100 + w2 * 15'd10 + w3;
               end else if (d2 != '0 && d3 != '0 && d4 != '0) begin
                  kind_in   = bfdd_pkg::KIND_NUMBER;
                  number_in = w1 * 15'd1000 + w2 * 15'd100 + w3 * 15'd10 + w4;
               end
            end
         end
         default: pos_in = POS_HEADER;
      endcase
   end

   assign rsp_valid_in = consume ? frame_done : (rsp_valid_ff && !rsp_if.ready);

   // Frame state and stored values
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_HEADER;
         target_ff <= '0;
         number_ff <= '0;
      end else if (consume) begin
         pos_ff    <= pos_in;
         target_ff <= target_in;
         number_ff <= number_in;
      end
   end

   // Payload capture
   always_ff @(posedge clock) begin
      if (consume && pos_ff == POS_FIRST) pay_first_ff <= in_byte_ff;
      if (consume && pos_ff == POS_SECOND) pay_second_ff <= in_byte_ff;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && frame_done) rsp_kind_ff <= kind_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.update_kind  = rsp_kind_ff;
   assign rsp_if.target_value = target_ff;
   assign rsp_if.number_value = number_ff;

`ifndef SYNTHESIS
   // A new result only follows a tail-position byte leaving the input register
   a_result_from_tail: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(pos_ff) == POS_TAIL && $past(in_valid_ff)))
      else $error("result raised without a completed frame");

   // Kind code three is never produced
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_kind_ff == bfdd_pkg::KIND_TARGET ||
                        rsp_kind_ff == bfdd_pkg::KIND_NUMBER ||
                        rsp_kind_ff == bfdd_pkg::KIND_NONE))
      else $error("illegal update kind");

   // A target update always stores a nonzero leading digit
   a_target_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == bfdd_pkg::KIND_TARGET) |-> target_ff != '0)
      else $error("target update stored zero");

   // A number update is nonzero and within the four-digit range
   a_number_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == bfdd_pkg::KIND_NUMBER) |->
      (number_ff != '0 && number_ff <= bfdd_pkg::NUMBER_MAX))
      else $error("number update out of range");
`endif

endmodule

// ----- dv/byte_frame_digit_decoder_test.sv -----
// Self-checking testbench for byte_frame_digit_decoder: directed frames, then random
// frames, broken frames and noise under several delimiter settings and backpressure.
// Depends on bfdd_pkg, bfdd_chan_if and the byte_frame_digit_decoder top level.
`timescale 1ns / 1ps

module byte_frame_digit_decoder_test;
   import bfdd_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned SEGMENT_BYTES = 180;
   localparam int unsigned SEGMENTS      = 6;

   typedef enum logic [1:0] {WAIT_HEADER, WAIT_FIRST, WAIT_SECOND, WAIT_TAIL} frame_pos_type;

   typedef struct {
      kind_type   kind;
      digit_type  target;
      number_type number;
   } frame_result_type;

   typedef struct {
      byte_type         data;
      bit               known;
      frame_result_type res;
   } stim_row_type;

   logic       clock;
   logic       reset      = 1'b1;
   logic       send_valid = 1'b0;
   byte_type   send_data  = '0;
   logic       recv_ready = 1'b0;
   logic       csr_wr_en  = 1'b0;
   csr_index_type csr_index = REG_HEADER;
   byte_type   csr_wdata  = '0;

   bfdd_req_if req_ch ();
   bfdd_rsp_if rsp_ch ();

   assign req_ch.valid   = send_valid;
   assign req_ch.rx_byte = send_data;
   assign rsp_ch.ready   = recv_ready;

   byte_frame_digit_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Decoder state as the testbench tracks it
   frame_pos_type frame_pos    = WAIT_HEADER;
   byte_type    first_payload  = '0;
   byte_type    second_payload = '0;
   digit_type   target_digit = '0;
   number_type  number_store = '0;
   byte_type    hdr_value    = HEADER_RESET;
   byte_type    tail_value   = TAIL_RESET;

   frame_result_type frames_due [$];
   frame_result_type due_frame;
   frame_result_type no_result = '{KIND_NONE, 4'd0, 15'd0};

   int unsigned send_idle   = 35;
   int unsigned recv_idle   = 54;
   int unsigned bytes_sent  = 0;
   int unsigned failures    = 0;
   int unsigned cycle_count = 0;

   byte_type hdr_plan  [SEGMENTS];
   byte_type tail_plan [SEGMENTS];

   // Directed frames at the reset delimiters (header 0x55, tail 0x6B)
   stim_row_type directed_rows [0:24] = '{
      '{8'h00, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},          // noise while waiting
      '{8'h55, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'hF0, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h00, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h6B, 1'b1, '{KIND_TARGET, 4'd15, 15'd0}},       // largest target
      '{8'h55, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'hFF, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'hFF, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h6B, 1'b1, '{KIND_NUMBER, 4'd15, NUMBER_MAX}},  // largest number
      '{8'h55, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h00, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h00, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h6B, 1'b1, '{KIND_NONE, 4'd15, NUMBER_MAX}},    // all-zero digits
      '{8'h55, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h12, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h30, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h55, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},          // bad tail, not a header
      '{8'h55, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h55, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},          // payload equal to header
      '{8'h6B, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},          // payload equal to tail
      '{8'h6B, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h55, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h12, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h30, 1'b0, '{KIND_NONE, 4'd0, 15'd0}},
      '{8'h6B, 1'b0, '{KIND_NONE, 4'd0, 15'd0}}           // three digits
   };

   // Clock and cycle limit
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Advance the frame tracker by one byte; returns 1 when a frame completes
   function automatic bit step_decoder(input byte_type b, output frame_result_type res);
      int d1, d2, d3, d4;
      res = no_result;
      case (frame_pos)
         WAIT_HEADER: begin
            if (b == hdr_value) frame_pos = WAIT_FIRST;
            return 1'b0;
         end
         WAIT_FIRST: begin
            first_payload = b;
            frame_pos = WAIT_SECOND;
            return 1'b0;
         end
         WAIT_SECOND: begin
            second_payload = b;
            frame_pos = WAIT_TAIL;
            return 1'b0;
         end
         default: begin
            frame_pos = WAIT_HEADER;
            if (b != tail_value) return 1'b0;
         end
      endcase
      d1 = int'(first_payload[7:4]);
      d2 = int'(first_payload[3:0]);
      d3 = int'(second_payload[7:4]);
      d4 = int'(second_payload[3:0]);
      res.kind = KIND_NUMBER;
      // Leading nonzero digits, zeros after them; anything else is ignored
      if (d1 == 0)
         res.kind = KIND_NONE;
      else if (d2 == 0 && d3 == 0 && d4 == 0) begin
         res.kind = KIND_TARGET;
         target_digit = digit_type'(d1);
      end else if (d2 != 0 && d3 == 0 && d4 == 0)
         number_store = number_type'(d1 * 10 + d2);
      else if (d2 != 0 && d3 != 0 && d4 == 0)
         number_store = number_type'(d1 * 100 + d2 * 10 + d3);
      else if (d2 != 0 && d3 != 0 && d4 != 0)
         number_store = number_type'(d1 * 1000 + d2 * 100 + d3 * 10 + d4);
      else
         res.kind = KIND_NONE;
      res.target = target_digit;
      res.number = number_store;
      return 1'b1;
   endfunction

   function automatic digit_type nonzero_digit();
      return digit_type'($urandom_range(15, 1));
   endfunction

   // Send one request byte; valid stays high into the next request unless a gap is drawn
   task automatic send_request(input byte_type b, input bit known,
                               input frame_result_type known_res);
      frame_result_type res;
      while ($urandom_range(99) < send_idle) begin
         send_valid <= 1'b0;
         @(posedge clock);
      end
      send_valid <= 1'b1;
      send_data  <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
      if (step_decoder(b, res)) begin
         if (known) frames_due.push_back(known_res);
         else frames_due.push_back(res);
      end
   endtask

   // Mostly well-formed frames with random digits, some broken frames and noise
   task automatic send_random_frame();
      byte_type    p1, p2, last;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick >= 85) begin
         send_request(byte_type'($urandom_range(255)), 1'b0, no_result);
         return;
      end
      case ($urandom_range(5))
         0: begin
            p1 = {nonzero_digit(), 4'h0};
            p2 = 8'h00;
         end
         1: begin
            p1 = {nonzero_digit(), nonzero_digit()};
            p2 = 8'h00;
         end
         2: begin
            p1 = {nonzero_digit(), nonzero_digit()};
            p2 = {nonzero_digit(), 4'h0};
         end
         3: begin
            p1 = {nonzero_digit(), nonzero_digit()};
            p2 = {nonzero_digit(), nonzero_digit()};
         end
         4: begin
            // digit patterns with a gap
            case ($urandom_range(2))
               0: begin
                  p1 = {4'h0, digit_type'($urandom_range(15))};
                  p2 = byte_type'($urandom_range(255));
               end
               1: begin
                  p1 = {nonzero_digit(), 4'h0};
                  p2 = {nonzero_digit(), digit_type'($urandom_range(15))};
               end
               default: begin
                  p1 = {nonzero_digit(), nonzero_digit()};
                  p2 = {4'h0, nonzero_digit()};
               end
            endcase
         end
         default: begin
            p1 = byte_type'($urandom_range(255));
            p2 = byte_type'($urandom_range(255));
         end
      endcase
      last = tail_value;
      if (pick >= 70) begin
         // wrong tail byte, often the header value
         if ($urandom_range(2) == 0 && hdr_value != tail_value)
            last = hdr_value;
         else
            while (last == tail_value) last = byte_type'($urandom_range(255));
      end
      send_request(hdr_value, 1'b0, no_result);
      send_request(p1, 1'b0, no_result);
      send_request(p2, 1'b0, no_result);
      send_request(last, 1'b0, no_result);
   endtask

   // Stop sending, collect every pending result and let the pipeline empty
   task automatic wait_idle();
      send_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_delimiters(input byte_type hdr, input byte_type tl);
      csr_wr_en <= 1'b1;
      csr_index <= REG_HEADER;
      csr_wdata <= hdr;
      @(posedge clock);
      csr_index <= REG_TAIL;
      csr_wdata <= tl;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      hdr_value  = hdr;
      tail_value = tl;
   endtask

   // Receiver stalls
   always @(posedge clock)
      recv_ready <= ($urandom_range(99) >= recv_idle);

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (frames_due.size() == 0) begin
            failures++;
            $display("%0t: expected no result, actual kind %0d target %0d number %0d",
                     $time, rsp_ch.update_kind, rsp_ch.target_value, rsp_ch.number_value);
         end else begin
            due_frame = frames_due.pop_front();
            if (rsp_ch.update_kind !== due_frame.kind) begin
               failures++;
               $display("%0t: update_kind expected %0d actual %0d",
                        $time, due_frame.kind, rsp_ch.update_kind);
            end
            if (rsp_ch.target_value !== due_frame.target) begin
               failures++;
               $display("%0t: target_value expected %0d actual %0d",
                        $time, due_frame.target, rsp_ch.target_value);
            end
            if (rsp_ch.number_value !== due_frame.number) begin
               failures++;
               $display("%0t: number_value expected %0d actual %0d",
                        $time, due_frame.number, rsp_ch.number_value);
            end
         end
      end
   end

   // Main sequence
   initial begin
      int seg;
      hdr_plan  = '{8'h00, 8'hFF, 8'hA5, 8'h00, HEADER_RESET, 8'h00};
      tail_plan = '{8'hFF, 8'h00, 8'hA5, 8'h00, TAIL_RESET, 8'h00};
      hdr_plan[3]  = byte_type'($urandom_range(255));
      tail_plan[3] = byte_type'($urandom_range(255));
      hdr_plan[5]  = byte_type'($urandom_range(255));
      tail_plan[5] = byte_type'($urandom_range(255));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].data, directed_rows[i].known, directed_rows[i].res);

      // Two delimiter settings per stall pattern
      for (seg = 0; seg < SEGMENTS; seg++) begin
         wait_idle();
         send_idle = (seg < 2) ? 35 : (seg < 4) ? 54 : 0;
         recv_idle = (seg < 2) ? 54 : (seg < 4) ? 35 : 0;
         set_delimiters(hdr_plan[seg], tail_plan[seg]);
         bytes_sent = 0;
         while (bytes_sent < SEGMENT_BYTES) send_random_frame();
      end

      wait_idle();
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
